[hw/rtl/pnt_pkg.sv]
package pnt_pkg;

  // fixed field widths
  localparam int NUMBER_BITS     = 32;
  localparam int SUM_BITS        = 35;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int FIRST_DIVISOR   = 2;

  // datapath commands from the controller
  typedef struct packed {
    logic load;       // capture number, divisor back to first, sum to one
    logic first_div;  // start dividing by the current divisor
    logic next_div;   // fold in the last result, step divisor, divide again
    logic div_step;   // one restoring division step
    logic publish;    // move the result into the output register
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic below_two;  // held number is 0 or 1
    logic div_last;   // the division finishes on this step
    logic d_gt_q;     // divisor exceeds quotient, trial range exhausted
  } dp_status_t;

endpackage

[hw/rtl/pnt_datapath.sv]
module pnt_datapath #(
  parameter int VALUE_BITS = pnt_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic [pnt_pkg::NUMBER_BITS-1:0] number_i,
  input  pnt_pkg::dp_cmd_t               cmd_i,
  output pnt_pkg::dp_status_t            status_o,
  output logic                           is_perfect_flag_o,
  output logic [pnt_pkg::SUM_BITS-1:0]    divisor_sum_o,
  output logic [pnt_pkg::NUMBER_BITS-1:0] tested_number_o
);
  import pnt_pkg::*;

  localparam int W  = VALUE_BITS;
  localparam int DW = (W + 1) / 2 + 1;
  localparam int CW = $clog2(W);
  localparam int IW = W + NUMBER_BITS;
  localparam int AW = ((W > SUM_BITS) ? W : SUM_BITS) + 2;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  logic [W-1:0]        n_q;
  logic [DW-1:0]       d_q;
  logic [SUM_BITS-1:0] sum_q;
  logic [W-1:0]        a_q;
  logic [DW:0]         r_q;
  logic [CW-1:0]       cnt_q;

  logic [IW-1:0]       in_wide;
  logic [IW-1:0]       n_wide;
  logic [W-1:0]        n_in;
  logic [DW:0]         trial;
  logic [DW+1:0]       sub;
  logic [AW-1:0]       q_add;
  logic [AW-1:0]       acc;
  logic [SUM_BITS-1:0] sum_next;
  logic                flag_next;

  assign in_wide = IW'(number_i);
  assign n_in    = in_wide[W-1:0];
  assign n_wide  = IW'(n_q);

  // restoring divider step: shift in next dividend bit, try subtracting
  assign trial = {r_q[DW-1:0], a_q[W-1]};
  assign sub   = {1'b0, trial} - {2'b00, d_q};

  // cofactor counted once when it equals the divisor
  assign q_add = (a_q != W'(d_q)) ? AW'(a_q) : '0;
  assign acc   = AW'(sum_q) + AW'(d_q) + q_add;

  always_comb begin
    sum_next = sum_q;
    if (r_q == '0) begin
      if (acc > AW'(SUM_MAX)) begin
        sum_next = SUM_MAX;
      end else begin
        sum_next = acc[SUM_BITS-1:0];
      end
    end
  end

  assign status_o.below_two = (n_q[W-1:1] == '0);
  assign status_o.div_last  = (cnt_q == '0);
  assign status_o.d_gt_q    = (W'(d_q) > a_q);

  assign flag_next = !status_o.below_two && (AW'(sum_q) == AW'(n_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q   <= n_in;
      d_q   <= DW'(FIRST_DIVISOR);
      sum_q <= SUM_BITS'(1);
    end
    if (cmd_i.first_div || cmd_i.next_div) begin
      a_q   <= n_q;
      r_q   <= '0;
      cnt_q <= CW'(W - 1);
    end
    if (cmd_i.next_div) begin
      sum_q <= sum_next;
      d_q   <= d_q + DW'(1);
    end
    if (cmd_i.div_step) begin
      a_q   <= {a_q[W-2:0], ~sub[DW+1]};
      r_q   <= sub[DW+1] ? trial : sub[DW:0];
      cnt_q <= cnt_q - CW'(1);
    end
    if (cmd_i.publish) begin
      is_perfect_flag_o <= flag_next;
      divisor_sum_o     <= status_o.below_two ? '0 : sum_q;
      tested_number_o   <= n_wide[NUMBER_BITS-1:0];
    end
  end

endmodule

[hw/rtl/pnt_ctrl.sv]
module pnt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  pnt_pkg::dp_status_t status_i,
  output pnt_pkg::dp_cmd_t    cmd_o
);
  import pnt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.below_two) begin
          state_d = S_DONE;
        end else begin
          cmd_o.first_div = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // stop once divisor squared would pass the number
        if (status_i.d_gt_q) begin
          state_d = S_DONE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/perfect_number_test.sv]
// perfect number test by trial division
//
// input channel: in_valid_i / in_stall_o with number_i. one number per
// transaction, low VALUE_BITS bits used. output channel: out_valid_o /
// out_stall_i with is_perfect_flag_o, divisor_sum_o and tested_number_o,
// one result transaction per input transaction, in order.
//
// one number is worked at a time. divisors d = 2, 3, ... are tried by a
// restoring divider that produces one quotient bit per cycle, and there
// are floor(sqrt(n)) trials; numbers 0 and 1 skip the trials. the next
// number is taken the cycle after the result is published.
//
// the result sits in an output register; a new number is accepted while
// it waits. if the receiver still stalls when the next result is ready,
// the block holds it internally and keeps in_stall_o high.
// reset clears the controller and the output valid; nothing is pending.
module perfect_number_test #(
  parameter int VALUE_BITS = pnt_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pnt_pkg::NUMBER_BITS-1:0] number_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           is_perfect_flag_o,
  output logic [pnt_pkg::SUM_BITS-1:0]    divisor_sum_o,
  output logic [pnt_pkg::NUMBER_BITS-1:0] tested_number_o
);
  import pnt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  pnt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pnt_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .number_i          (number_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .is_perfect_flag_o (is_perfect_flag_o),
    .divisor_sum_o     (divisor_sum_o),
    .tested_number_o   (tested_number_o)
  );

  // a flagged result carries a sum equal to the tested number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_perfect_flag_o |->
      divisor_sum_o == SUM_BITS'(tested_number_o))
    else $error("perfect flag with mismatching sum");

  // numbers below two report zero and no flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tested_number_o[NUMBER_BITS-1:1] == '0 |->
      divisor_sum_o == '0 && !is_perfect_flag_o)
    else $error("small number gave nonzero sum or flag");

  // a new transaction is never taken while one is being worked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while busy");

  // no result is published without an item in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> in_stall_o)
    else $error("publish while idle");

endmodule

[bench/perfect_number_test_tb.sv]
`timescale 1ns / 1ps

module perfect_number_test_tb;

  import pnt_pkg::*;

  localparam int VB            = VALUE_BITS_DEF;
  localparam int MAX_GAP       = 24;
  localparam int MAX_STALL     = 16;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RANDOM_ITEMS  = 80;

  typedef struct {
    logic                   flag;
    logic [SUM_BITS-1:0]    sum;
    logic [NUMBER_BITS-1:0] number;
  } aliquot_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_CHOPPY,
    STALL_LONG
  } stall_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall_o;
  logic [NUMBER_BITS-1:0] number = '0;
  logic                   out_valid_o;
  logic                   out_stall = 1'b0;
  logic                   is_perfect_flag_o;
  logic [SUM_BITS-1:0]    divisor_sum_o;
  logic [NUMBER_BITS-1:0] tested_number_o;

  logic [NUMBER_BITS-1:0] numbers_to_send [$];
  aliquot_t               expected_sums [$];

  int          mismatches = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  logic [7:0]  mode_timer = '0;
  stall_mode_e stall_mode = STALL_NONE;
  longint      cycles = 0;
  longint      cycle_limit = 64'd1_000_000_000;

  perfect_number_test #(
    .VALUE_BITS(VB)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .number_i         (number),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .is_perfect_flag_o(is_perfect_flag_o),
    .divisor_sum_o    (divisor_sum_o),
    .tested_number_o  (tested_number_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // sum of proper divisors by trial division, saturating at the sum width
  function automatic aliquot_t aliquot_of(logic [NUMBER_BITS-1:0] raw);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned acc;
    longint unsigned sum_max;
    aliquot_t        res;
    sum_max = (64'd1 << SUM_BITS) - 1;
    n = raw & ((64'd1 << VB) - 1);
    acc = 0;
    if (n >= 2) begin
      acc = 1;
      d = 2;
      while (d <= n / d) begin
        q = n / d;
        if (n % d == 0) begin
          acc = (acc + d > sum_max) ? sum_max : acc + d;
          if (q != d) acc = (acc + q > sum_max) ? sum_max : acc + q;
        end
        d++;
      end
    end
    res.flag   = (n >= 2) && (acc == n);
    res.sum    = acc[SUM_BITS-1:0];
    res.number = n[NUMBER_BITS-1:0];
    return res;
  endfunction

  // sender: bursts of transactions with random gaps in between
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_sums.push_back(aliquot_of(number));
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0 || numbers_to_send.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          in_valid <= 1'b1;
          number <= numbers_to_send.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern, switching style each time the 8-bit mode timer wraps
  always @(posedge clk_i) begin
    mode_timer <= mode_timer + 1'b1;
    if (mode_timer == '0) stall_mode <= stall_mode_e'($urandom_range(0, 2));
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      case (stall_mode)
        STALL_CHOPPY: begin
          out_stall <= 1'($urandom_range(0, 1));
        end
        STALL_LONG: begin
          if ($urandom_range(0, 15) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(3, MAX_STALL - 1);
          end else begin
            out_stall <= 1'b0;
          end
        end
        default: begin
          out_stall <= 1'b0;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    aliquot_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $error("result transaction with nothing pending: number %0d sum %0d",
               tested_number_o, divisor_sum_o);
        mismatches++;
      end else begin
        want = expected_sums.pop_front();
        if (is_perfect_flag_o !== want.flag) begin
          $error("is_perfect_flag: expected %0d, actual %0d", want.flag, is_perfect_flag_o);
          mismatches++;
        end
        if (divisor_sum_o !== want.sum) begin
          $error("divisor_sum: expected %0d, actual %0d", want.sum, divisor_sum_o);
          mismatches++;
        end
        if (tested_number_o !== want.number) begin
          $error("tested_number: expected %0d, actual %0d", want.number, tested_number_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > cycle_limit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [NUMBER_BITS-1:0] directed [$];
    logic [NUMBER_BITS-1:0] val;
    longint unsigned        root;
    longint unsigned        probe;
    longint                 budget;
    int                     k;
    int                     d;

    // below two, smallest prime, squares, perfect numbers, primes, powers of two,
    // an odd abundant number and the all-ones extreme
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12, 32'd28,
                 32'd49, 32'd97, 32'd496, 32'd945, 32'd8128, 32'd65535, 32'd65536,
                 32'd65521, 32'hFFFF_FFFF, 32'd33550336, 32'd1, 32'd6, 32'd0};
    foreach (directed[i]) numbers_to_send.push_back(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: val = 32'd6;
            1: val = 32'd28;
            2: val = 32'd496;
            default: val = 32'd8128;
          endcase
        end
        1: begin
          d = $urandom_range(2, 300);
          val = d * d;
        end
        2: val = $urandom_range(0, 3);
        default: begin
          // mostly narrow values so the trial count stays small
          k = $urandom_range(1, 18);
          val = $urandom() & ((32'd1 << k) - 1);
        end
      endcase
      numbers_to_send.push_back(val);
    end

    // slowest case: every trial, every gap and every stall at its longest
    budget = 0;
    foreach (numbers_to_send[i]) begin
      root = 0;
      for (int b = 16; b >= 0; b--) begin
        probe = root | (64'd1 << b);
        if (probe * probe <= numbers_to_send[i]) root = probe;
      end
      budget += (VB + 1) * (root + 2) + 8 + MAX_GAP + MAX_STALL;
    end
    cycle_limit = 4 * budget + 10_000;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_to_send.size() != 0 || in_valid || expected_sums.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pnt_pkg.sv
hw/rtl/pnt_datapath.sv
hw/rtl/pnt_ctrl.sv
hw/rtl/perfect_number_test.sv
bench/perfect_number_test_tb.sv
